// ===== sv/chl_pkg.sv =====
package chl_pkg;

  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;
  localparam int POS_W   = 6;
  localparam int XFER_W  = 32;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_CONTAINS = 3'd2,
    REQ_READ     = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_kind_t;

  localparam logic CFG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [XFER_W-1:0] handle;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [XFER_W-1:0]  read_handle;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               add_en;
    logic               shift_en;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos;
  } cell_ctl_t;

  // Passed from each cell to its right-hand neighbor.
  typedef struct packed {
    logic              found;
    logic              rd_hit;
    logic [XFER_W-1:0] rd_data;
  } chain_t;

endpackage

// ===== sv/compacting_handle_list_top.sv =====
// Ordered handle list held in a row of cells, one entry per cell. A request is
// taken when start is high and busy is low; busy then stays high
// while every cell compares, shifts or loads in parallel, and the result is on
// rsp with done high for exactly one cycle after that. A new request can be
// taken in the same cycle that the previous result is shown. The result is not
// held: the receiver must take it in the cycle done is high.
module compacting_handle_list_top #(
  parameter int DEPTH        = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  chl_pkg::req_t                  req,
  output logic                           done,
  output chl_pkg::rsp_t                  rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import chl_pkg::*;

  localparam int DEPTH_CLIP = (DEPTH > 127) ? 127 : DEPTH;

  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   eff_cap;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               exec;
  req_t               req_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  cell_ctl_t          ctl;
  logic               can_add;
  logic               success_next;
  rsp_t               rsp_next;

  chain_t                  link [DEPTH+1];
  logic [HANDLE_WIDTH-1:0] entry [DEPTH];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign eff_cap = (int'(capacity) > DEPTH) ? CAP_W'(DEPTH_CLIP) : capacity;

  // Request capture.
  assign busy = exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec <= 1'b0;
    end else begin
      exec <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  assign handle_q = HANDLE_WIDTH'(req_q.handle);
  assign can_add  = (count < eff_cap) && (int'(count) < DEPTH);

  always_comb begin
    ctl.add_en   = exec && (req_q.req_type == REQ_ADD) && can_add;
    ctl.shift_en = exec && (req_q.req_type == REQ_REMOVE);
    ctl.count    = count;
    ctl.pos      = req_q.position;
  end

  // Cell row.
  assign link[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_WIDTH-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    chl_cell #(
      .IDX          (i),
      .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .handle   (handle_q),
      .nbr      (nbr),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .entry    (entry[i])
    );
  end

  // Count update and result.
  always_comb begin
    count_next   = count;
    success_next = 1'b0;
    unique case (req_q.req_type)
      REQ_ADD: begin
        if (can_add) begin
          count_next   = count + 1'b1;
          success_next = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (link[DEPTH].found) begin
          count_next   = count - 1'b1;
          success_next = 1'b1;
        end
      end
      REQ_CONTAINS: success_next = link[DEPTH].found;
      REQ_READ:     success_next = link[DEPTH].rd_hit;
      REQ_CLEAR:    count_next   = '0;
      default: begin
      end
    endcase

    rsp_next.success     = success_next;
    rsp_next.read_handle = (req_q.req_type == REQ_READ) ? link[DEPTH].rd_data : '0;
    rsp_next.entry_count = count_next;
    rsp_next.is_empty    = (count_next == '0);
    rsp_next.is_full     = (count_next >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= exec;
      if (exec) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== sv/chl_cell.sv =====
module chl_cell #(
  parameter int IDX          = 0,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                    clk,
  input  chl_pkg::cell_ctl_t      ctl,
  input  logic [HANDLE_WIDTH-1:0] handle,
  input  logic [HANDLE_WIDTH-1:0] nbr,
  input  chl_pkg::chain_t         link_in,
  output chl_pkg::chain_t         link_out,
  output logic [HANDLE_WIDTH-1:0] entry
);
  import chl_pkg::*;

  logic occupied;
  logic match;
  logic sel;

  assign occupied = int'(ctl.count) > IDX;
  assign match    = occupied && (entry == handle);
  assign sel      = occupied && (int'(ctl.pos) == IDX);

  assign link_out.found   = link_in.found | match;
  assign link_out.rd_hit  = link_in.rd_hit | sel;
  assign link_out.rd_data = link_in.rd_data | (sel ? XFER_W'(entry) : '0);

  // On a remove, every cell from the first match on copies its neighbor.
  always_ff @(posedge clk) begin
    if (ctl.add_en && (int'(ctl.count) == IDX)) begin
      entry <= handle;
    end else if (ctl.shift_en && link_out.found) begin
      entry <= nbr;
    end
  end

endmodule
